// ===== hdl/sfir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfir_pkg
// Shared types, constants and the rate table of the still-frame retimer.
// ----------------------------------------------------------------------------
package sfir_pkg;

    localparam int TIME_WIDTH_DEF = 40;
    localparam int PTS_W          = 40;
    localparam int FN_W           = 32;

    localparam logic [1:0] CMD_OUT_REQ   = 2'd0;
    localparam logic [1:0] CMD_FRAME     = 2'd1;
    localparam logic [1:0] CMD_SEEK      = 2'd2;
    localparam logic [1:0] CMD_SEEK_DONE = 2'd3;

    localparam logic [2:0] KIND_DUP     = 3'd0;
    localparam logic [2:0] KIND_FETCH   = 3'd1;
    localparam logic [2:0] KIND_ADJUST  = 3'd2;
    localparam logic [2:0] KIND_CAPTURE = 3'd3;
    localparam logic [2:0] KIND_SEEK    = 3'd4;

    localparam logic [2:0] REG_START  = 3'd0;
    localparam logic [2:0] REG_DUR    = 3'd1;
    localparam logic [2:0] REG_STREAM = 3'd2;
    localparam logic [2:0] REG_INC    = 3'd3;
    localparam logic [2:0] REG_NUM    = 3'd4;
    localparam logic [2:0] REG_DEN    = 3'd5;

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] n;
        logic [31:0] d;
    } t_rate;

    localparam t_rate RATE_TABLE [8] = '{
        '{32'd40000, 32'd40000, 32'd1000, 32'd25000},
        '{32'd20000, 32'd20000, 32'd1000, 32'd50000},
        '{32'd16661, 32'd16671, 32'd1000, 32'd60000},
        '{32'd16678, 32'd16688, 32'd1001, 32'd60000},
        '{32'd33360, 32'd33371, 32'd1001, 32'd30000},
        '{32'd41700, 32'd41710, 32'd1001, 32'd24000},
        '{32'd33328, 32'd33338, 32'd1000, 32'd30000},
        '{32'd41660, 32'd41670, 32'd1000, 32'd24000}
    };

    // divider request / status
    typedef struct packed {
        logic        start;
        logic [63:0] dvd_hi;
        logic [63:0] dvd_lo;
        logic [63:0] dvs;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic        over;
        logic [63:0] quo;
        logic [63:0] rem;
    } t_div_rsp;

endpackage

// ===== hdl/sfir_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfir_div
// Shared restoring divider, 128 by 64 bit, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module sfir_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfir_pkg::t_div_req i_req,
    output sfir_pkg::t_div_rsp o_rsp
);
    import sfir_pkg::*;

    logic [127:0] r_dvd, n_dvd;
    logic [64:0]  r_rem, n_rem;
    logic [63:0]  r_dvs;
    logic [63:0]  r_quo, n_quo;
    logic         r_over, n_over;
    logic [6:0]   r_cnt, n_cnt;
    logic         r_busy, r_done;

    always_comb begin
        logic [64:0] rm;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_over = r_over;
        rm     = r_rem;
        for (int k = 0; k < 2; k++) begin
            rm = {rm[63:0], n_dvd[127]};
            n_dvd = {n_dvd[126:0], 1'b0};
            if (rm >= {1'b0, r_dvs}) begin
                rm = rm - {1'b0, r_dvs};
                if (r_cnt > 7'd31) n_over = 1'b1;
                n_quo = {n_quo[62:0], 1'b1};
            end else begin
                n_quo = {n_quo[62:0], 1'b0};
            end
        end
        n_rem = rm;
        n_cnt = r_cnt - 7'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 7'd63;
            r_dvd  <= {i_req.dvd_hi, i_req.dvd_lo};
            r_dvs  <= i_req.dvs;
            r_rem  <= '0;
            r_quo  <= '0;
            r_over <= 1'b0;
        end else if (r_busy) begin
            r_dvd  <= n_dvd;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_over <= n_over;
            r_cnt  <= n_cnt;
            if (r_cnt == 7'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.over = r_over;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem[63:0];
endmodule

// ===== hdl/still_frame_insertion_retimer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// still_frame_insertion_retimer_core
// Freezes one video frame: answers output requests with repeated stills,
// captures and shifts upstream frames and translates seek times.
//
// Input channel: command, pts, pts_valid, frame_number, fine_seek with
// i_in_valid / o_in_stall. Output channel: kind, out_pts, out_frame_number,
// out_pts_valid, out_fine_seek with o_out_valid / i_out_stall. One result
// per request, none for a seek-succeeded command.
// Configuration: i_cfg_valid / o_cfg_ready with a register index and data;
// ready only while idle, and a pending write holds off new requests.
// A frame, seek or fetch answer passes S_WIN, S_DEC and S_OUT; a still in
// increment mode with a zero time base also passes S_STILL. A still with
// an exact rate match runs one division in the shared 128/64 divider.
// When the rate needs the factor test, one or two more divisions run: it
// falls back to increment mode after a failed one, else the still follows.
// One request at a time; the block stalls its input while busy and while a
// result waits in the output register, holds the result while the receiver
// stalls, and takes the next request the cycle after the result is taken.
// Reset: state to its reset values, configuration to defaults.
// ----------------------------------------------------------------------------
module still_frame_insertion_retimer_core #(
    parameter int TIME_WIDTH = sfir_pkg::TIME_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [39:0] i_pts,
    input  logic        i_pts_valid,
    input  logic [31:0] i_frame_number,
    input  logic        i_fine_seek,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [39:0] o_out_pts,
    output logic [31:0] o_out_frame_number,
    output logic        o_out_pts_valid,
    output logic        o_out_fine_seek,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import sfir_pkg::*;

    localparam logic [63:0] TMAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - TIME_WIDTH);

    localparam logic [3:0] S_IDLE = 4'd0, S_WIN = 4'd1, S_DEC = 4'd2, S_MUL1 = 4'd3,
                           S_MUL2 = 4'd4, S_MUL3 = 4'd5, S_DIVW = 4'd6, S_STILL = 4'd7,
                           S_OUT = 4'd8, S_FAC = 4'd9, S_FACW = 4'd10, S_FAC2 = 4'd11,
                           S_FACW2 = 4'd12, S_MUL4 = 4'd13;

    logic [3:0] r_st;

    logic [31:0] r_start, r_inc, r_num, r_den;
    logic [24:0] r_dur;
    logic [39:0] r_stream;

    logic        r_held, r_after, r_cap_en;
    logic [63:0] r_still, r_fstart, r_flast;
    logic [31:0] r_cnt_out, r_rep;
    logic [40:0] r_flen;
    logic        r_flen_dirty;

    logic [1:0]  r_cmd;
    logic [63:0] r_pts;
    logic        r_pv, r_fine;
    logic [31:0] r_fn;

    logic [63:0] r_wb, r_we;
    logic [63:0] r_a, r_t1, r_t2;
    logic [63:0] r_lo, r_hi;
    logic [31:0] r_tn, r_td;
    logic        r_tbm;
    logic [63:0] r_nm;

    logic        r_ov;
    logic [2:0]  r_kind;
    logic [63:0] r_opts;
    logic [31:0] r_ofn;
    logic        r_opv, r_ofine;

    t_div_req div_req;
    t_div_rsp div_rsp;

    sfir_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = (s[64] || s[63:0] > TMAX) ? TMAX : s[63:0];
    endfunction

    // window, combinational over the registers
    logic [63:0] w_b, w_e, w_b0, w_e0;
    always_comb begin
        w_b0 = 64'(r_start) * 64'd1000;
        w_e0 = w_b0 + 64'(r_dur) * 64'd1000;
        if (64'(r_stream) < w_b0) begin
            w_b = w_b0 - 64'(r_stream);
            w_e = w_e0 - 64'(r_stream);
        end else if (64'(r_stream) < w_e0) begin
            w_b = '0;
            w_e = w_e0 - 64'(r_stream);
        end else begin
            w_b = '0;
            w_e = '0;
        end
        if (w_b > TMAX) w_b = TMAX;
        if (w_e > TMAX) w_e = TMAX;
    end

    logic in_acc;
    logic cfg_acc;
    assign in_acc = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_st != S_IDLE) || r_ov || r_flen_dirty || i_cfg_valid;
    assign o_cfg_ready = (r_st == S_IDLE);
    assign cfg_acc = i_cfg_valid && o_cfg_ready;

    // factor test helpers: a > b divisible
    logic [63:0] fa, fb;
    always_comb begin
        fa = '0; fb = '0;
        div_req = '0;
        case (r_st)
            S_FAC: begin
                fa = (64'(r_tn) > 64'(r_num)) ? 64'(r_tn) : 64'(r_num);
                fb = (64'(r_tn) > 64'(r_num)) ? 64'(r_num) : 64'(r_tn);
                div_req.start  = 1'b1;
                div_req.dvd_lo = fa;
                div_req.dvs    = fb;
            end
            S_FAC2: begin
                fa = (64'(r_td) > 64'(r_den)) ? 64'(r_td) : 64'(r_den);
                fb = (64'(r_td) > 64'(r_den)) ? 64'(r_den) : 64'(r_td);
                div_req.start  = 1'b1;
                div_req.dvd_lo = fa;
                div_req.dvs    = fb;
            end
            S_MUL4: begin
                div_req.start  = 1'b1;
                div_req.dvd_hi = r_hi;
                div_req.dvd_lo = r_lo;
                div_req.dvs    = 64'(r_den) * 64'd100;
            end
            default: ;
        endcase
    end

    logic [31:0] lk_n, lk_d;
    always_comb begin
        lk_n = '0; lk_d = '0;
        for (int i = 7; i >= 0; i--) begin
            if (r_inc >= RATE_TABLE[i].lo && r_inc <= RATE_TABLE[i].hi) begin
                lk_n = RATE_TABLE[i].n;
                lk_d = RATE_TABLE[i].d;
            end
        end
    end

    logic [63:0] np;
    assign np = r_tbm ? sat_add(r_fstart, div_rsp.over ? 64'hFFFF_FFFF_FFFF_FFFF
                                                       : div_rsp.quo)
                      : sat_add(r_still, 64'(r_inc));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_start <= '0; r_dur <= 25'd10000; r_stream <= '0;
            r_inc <= 32'd40000; r_num <= 32'd1000; r_den <= 32'd25000;
            r_held <= 1'b0; r_after <= 1'b0; r_cap_en <= 1'b1;
            r_still <= '0; r_fstart <= '0; r_flast <= '0;
            r_cnt_out <= '0; r_rep <= '0;
            r_flen_dirty <= 1'b1;
            r_ov <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) r_ov <= 1'b0;
            if (cfg_acc) begin
                case (i_cfg_index)
                    REG_START:  begin r_start  <= i_cfg_data[31:0]; r_flen_dirty <= 1'b1; end
                    REG_DUR:    begin r_dur    <= i_cfg_data[24:0]; r_flen_dirty <= 1'b1; end
                    REG_STREAM: begin r_stream <= i_cfg_data[39:0]; r_flen_dirty <= 1'b1; end
                    REG_INC:    begin r_inc    <= i_cfg_data[31:0]; r_flen_dirty <= 1'b1; end
                    REG_NUM:    begin r_num    <= i_cfg_data[31:0]; r_flen_dirty <= 1'b1; end
                    REG_DEN:    begin r_den    <= i_cfg_data[31:0]; r_flen_dirty <= 1'b1; end
                    default: ;
                endcase
            end else if (r_flen_dirty) begin
                r_flen <= 41'(w_e - w_b);
                r_flen_dirty <= 1'b0;
            end
            case (r_st)
                S_IDLE: if (in_acc) begin
                    r_cmd <= i_command;
                    r_pts <= 64'(i_pts) & TMAX;
                    r_pv <= i_pts_valid;
                    r_fn <= i_frame_number;
                    r_fine <= i_fine_seek;
                    r_st <= S_WIN;
                end
                S_WIN: begin
                    r_wb <= w_b;
                    r_we <= w_e;
                    r_tn <= lk_n;
                    r_td <= lk_d;
                    r_st <= S_DEC;
                end
                S_DEC: begin
                    r_kind <= KIND_FETCH; r_opts <= '0; r_ofn <= '0;
                    r_opv <= 1'b0; r_ofine <= 1'b0;
                    r_st <= S_OUT;
                    case (r_cmd)
                        CMD_OUT_REQ: if (r_held && r_still < r_we) begin
                            if (r_num == 32'd0 || r_den == 32'd0 || r_td == 32'd0) begin
                                r_tbm <= 1'b0; r_st <= S_STILL;
                            end else if (r_tn == r_num && r_td == r_den) begin
                                r_tbm <= 1'b1; r_st <= S_MUL1;
                            end else begin
                                r_st <= S_FAC;
                            end
                        end
                        CMD_FRAME: begin
                            r_after <= 1'b0;
                            if (!r_pv || r_pts < r_wb) begin
                                r_kind <= KIND_ADJUST;
                                r_opts <= r_pv ? r_pts : '0;
                                r_ofn <= r_fn; r_opv <= r_pv;
                            end else begin
                                logic cen;
                                cen = r_cap_en;
                                if (r_after && r_pts > r_wb + 64'd999) cen = 1'b0;
                                r_cap_en <= cen;
                                r_opv <= 1'b1;
                                if (!r_held && cen) begin
                                    r_held <= 1'b1; r_still <= r_pts; r_cnt_out <= r_fn;
                                    r_rep <= '0; r_fstart <= r_pts; r_flast <= r_pts;
                                    r_kind <= KIND_CAPTURE; r_opts <= r_pts; r_ofn <= r_fn;
                                end else begin
                                    r_kind <= KIND_ADJUST;
                                    r_opts <= sat_add(r_pts, 64'(r_flen));
                                    r_ofn <= r_fn + r_rep;
                                end
                            end
                        end
                        CMD_SEEK: begin
                            r_held <= 1'b0;
                            r_kind <= KIND_SEEK; r_opv <= 1'b1; r_ofine <= r_fine;
                            if (r_pts >= r_wb && r_pts <= r_we) r_opts <= r_wb;
                            else if (r_pts > r_we) r_opts <= r_pts - (r_we - r_wb);
                            else r_opts <= r_pts;
                        end
                        default: begin
                            r_after <= 1'b1; r_cap_en <= 1'b1; r_st <= S_IDLE;
                        end
                    endcase
                end
                S_FAC: r_st <= S_FACW;
                S_FACW: if (div_rsp.done) begin
                    if (r_tn == r_num || div_rsp.rem != '0) begin
                        r_tbm <= 1'b0; r_st <= S_STILL;
                    end else begin
                        r_nm <= div_rsp.quo; r_st <= S_FAC2;
                    end
                end
                S_FAC2: r_st <= S_FACW2;
                S_FACW2: if (div_rsp.done) begin
                    if (r_td != r_den && div_rsp.rem == '0 && div_rsp.quo == r_nm) begin
                        r_tbm <= 1'b1; r_st <= S_MUL1;
                    end else begin
                        r_tbm <= 1'b0; r_st <= S_STILL;
                    end
                end
                S_MUL1: begin
                    r_a <= 64'(r_num) * 64'(33'(r_rep) + 33'd1);
                    r_st <= S_MUL2;
                end
                S_MUL2: begin
                    r_t1 <= 64'(r_a[31:0]) * 64'd100000000;
                    r_t2 <= 64'(r_a[63:32]) * 64'd100000000;
                    r_st <= S_MUL3;
                end
                S_MUL3: r_st <= S_MUL4;
                S_MUL4: r_st <= S_DIVW;
                S_DIVW: if (div_rsp.done) r_st <= S_STILL;
                S_STILL: begin
                    r_still <= np;
                    r_st <= S_OUT;
                    if (np > r_we) begin
                        r_flen <= (r_flast >= r_fstart) ? 41'(r_flast - r_fstart) : '0;
                        r_kind <= KIND_FETCH;
                    end else begin
                        r_cnt_out <= r_cnt_out + 32'd1;
                        r_rep <= r_rep + 32'd1;
                        r_flast <= np;
                        r_after <= 1'b0;
                        r_kind <= KIND_DUP; r_opts <= np;
                        r_ofn <= r_cnt_out + 32'd1; r_opv <= 1'b1;
                    end
                end
                S_OUT: begin
                    r_ov <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    logic [63:0] d_lo1, d_lo2, d_hi;
    logic        c1, c2;
    always_comb begin
        {c1, d_lo1} = {1'b0, r_t1} + {1'b0, r_t2[31:0], 32'd0};
        {c2, d_lo2} = {1'b0, d_lo1} + {1'b0, 64'(r_den) * 64'd49};
        d_hi = 64'(r_t2[63:32]) + 64'(c1) + 64'(c2);
    end

    // 128-bit dividend assembly, registered before the divider starts
    always_ff @(posedge i_clk) begin
        if (r_st == S_MUL3) begin
            r_lo <= d_lo2;
            r_hi <= d_hi;
        end
    end

    assign o_out_valid        = r_ov;
    assign o_kind             = r_kind;
    assign o_out_pts          = r_opts[39:0];
    assign o_out_frame_number = r_ofn;
    assign o_out_pts_valid    = r_opv;
    assign o_out_fine_seek    = r_ofine;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> o_in_stall) else $error("accept while busy");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_kind)))
        else $error("result dropped");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.busy |-> (r_st == S_DIVW || r_st == S_FACW || r_st == S_FACW2))
        else $error("divider busy out of wait");
endmodule
